### src/tnec_pkg.sv
// Shared types, constants and the month table for the timestamped name expiry check.
// Used by tnec_ctrl, tnec_dp and timestamped_name_expiry_check_core.
// No dependencies.
package tnec_pkg;

  // Field widths
  localparam int CUTOFF_W = 40;
  localparam int EPOCH_W  = 38;
  localparam int DAYS_W   = 22;
  localparam int TOD_W    = 19;

  // Name characters
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Field lengths and the saturation point of the byte count
  localparam logic [3:0] DATE_LEN  = 4'd8;
  localparam logic [3:0] TIME_LEN  = 4'd6;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] YEAR_END  = 4'd4;
  localparam logic [3:0] MONTH_END = 4'd6;
  localparam logic [3:0] HOUR_END  = 4'd2;
  localparam logic [3:0] MINUTE_END = 4'd4;

  // Calendar constants
  localparam logic [13:0] YEAR_BASE  = 14'd1970;
  localparam logic [13:0] YEAR_LIMIT = 14'd9999;
  // leaps through 1969: 492 - 19 + 4
  localparam logic [DAYS_W-1:0] LEAPS_BASE = 22'd477;
  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 22'd365;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  // floor(x / 100) = (x * 5243) >> 19 for x below 10000
  localparam logic [26:0] RECIP_100   = 27'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Parse phase of the character scanner
  typedef enum logic [1:0] {
    PH_SEEK,
    PH_DATE,
    PH_TIME,
    PH_DONE
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAYS,
    ST_MONTH,
    ST_MUL,
    ST_SUM,
    ST_CMP,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // character transfer this cycle
    logic year_en;   // clamp year, divide by 100
    logic days_en;   // whole-year day count
    logic month_en;  // add month and day
    logic mul_en;    // days to seconds, time of day
    logic sum_en;    // final sum
    logic res_en;    // load result, clear parser
  } cmd_t;

  // Days in the months before month index m (0 = January)
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### src/tnec_ctrl.sv
// Controller state machine: character intake, epoch calculation steps, result handshake.
// Depends on tnec_pkg.
module tnec_ctrl import tnec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last_char,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && last_char) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.year_en = 1'b1;
        state_next  = ST_DAYS;
      end
      ST_DAYS: begin
        cmd.days_en = 1'b1;
        state_next  = ST_MONTH;
      end
      ST_MONTH: begin
        cmd.month_en = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.res_en = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // No character is taken while a result is pending
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("character intake open while result pending");

  // The final character starts the calculation
  a_last_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_char) |=> (state == ST_YEAR))
    else $error("last character did not start calculation");

  // Result load is followed by a valid result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.res_en |=> out_valid)
    else $error("result not presented after load");

endmodule

### src/tnec_dp.sv
// Datapath: character parser registers, calendar arithmetic steps, cutoff register, result.
// Depends on tnec_pkg; steered by tnec_ctrl commands.
module tnec_dp import tnec_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [7:0]          name_char,
  input  logic                cutoff_we,
  input  logic [CUTOFF_W-1:0] cutoff_wdata,
  output logic                eligible,
  output logic                well_formed,
  output logic [EPOCH_W-1:0]  epoch_seconds
);

  // Parser state
  phase_t      phase, phase_next;
  logic [3:0]  count, count_next;
  logic        malformed, malformed_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;

  logic [CUTOFF_W-1:0] cutoff;

  logic       is_digit;
  logic [3:0] digit;
  logic [3:0] count_inc;

  // Calculation registers
  logic        ok;
  logic [13:0] yc;
  logic [6:0]  q100;
  logic        leap;
  logic [DAYS_W-1:0] ydays;
  logic [DAYS_W-1:0] days;
  logic [EPOCH_W-1:0] dsecs;
  logic [TOD_W-1:0]   tod;
  logic [EPOCH_W-1:0] epoch_sum;

  // Step combinational values
  logic [13:0] yc_c;
  logic [26:0] qprod;
  logic [13:0] prod100;
  logic        leap_c;
  logic [13:0] yoff;
  logic        month_ok;
  logic [3:0]  month_idx;
  logic [8:0]  mdays;

  // Cutoff register
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= '0;
    end else if (cutoff_we) begin
      cutoff <= cutoff_wdata;
    end
  end

  // Character classification
  assign is_digit  = (name_char >= CH_ZERO) && (name_char <= CH_NINE);
  assign digit     = is_digit ? name_char[3:0] : 4'd0;
  assign count_inc = (count == COUNT_MAX) ? count : count + 4'd1;

  // Parser next state
  always_comb begin
    phase_next     = phase;
    count_next     = count;
    malformed_next = malformed;
    year_next      = year;
    month_next     = month;
    day_next       = day;
    hour_next      = hour;
    minute_next    = minute;
    second_next    = second;
    case (phase)
      PH_SEEK: begin
        if (name_char == CH_DASH) begin
          phase_next = PH_DATE;
          count_next = 4'd0;
        end
      end
      PH_DATE: begin
        if (name_char == CH_DASH) begin
          if (count != DATE_LEN) malformed_next = 1'b1;
          phase_next = PH_TIME;
          count_next = 4'd0;
        end else begin
          count_next = count_inc;
          if (!is_digit || count >= DATE_LEN) begin
            malformed_next = 1'b1;
          end else if (count < YEAR_END) begin
            year_next = 14'(year * 14'd10 + 14'(digit));
          end else if (count < MONTH_END) begin
            month_next = 7'(month * 7'd10 + 7'(digit));
          end else begin
            day_next = 7'(day * 7'd10 + 7'(digit));
          end
        end
      end
      PH_TIME: begin
        if (name_char == CH_DOT) begin
          if (count != TIME_LEN) malformed_next = 1'b1;
          phase_next = PH_DONE;
        end else begin
          count_next = count_inc;
          if (!is_digit || count >= TIME_LEN) begin
            malformed_next = 1'b1;
          end else if (count < HOUR_END) begin
            hour_next = 7'(hour * 7'd10 + 7'(digit));
          end else if (count < MINUTE_END) begin
            minute_next = 7'(minute * 7'd10 + 7'(digit));
          end else begin
            second_next = 7'(second * 7'd10 + 7'(digit));
          end
        end
      end
      default: begin
        // trailing characters ignored
      end
    endcase
  end

  // Parser registers; cleared when the result is loaded
  always_ff @(posedge clk) begin
    if (rst || cmd.res_en) begin
      phase     <= PH_SEEK;
      count     <= 4'd0;
      malformed <= 1'b0;
      year      <= '0;
      month     <= '0;
      day       <= '0;
      hour      <= '0;
      minute    <= '0;
      second    <= '0;
    end else if (cmd.take) begin
      phase     <= phase_next;
      count     <= count_next;
      malformed <= malformed_next;
      year      <= year_next;
      month     <= month_next;
      day       <= day_next;
      hour      <= hour_next;
      minute    <= minute_next;
      second    <= second_next;
    end
  end

  // Year step: clamp, divide by 100 through the reciprocal
  assign yc_c  = (year >= YEAR_LIMIT || year < YEAR_BASE) ? YEAR_BASE : year;
  assign qprod = 27'(yc_c) * RECIP_100;

  // Leap rule and whole-year days
  assign prod100 = 14'(q100) * 14'd100;
  assign leap_c  = (yc[1:0] == 2'b00) && ((yc != prod100) || (q100[1:0] == 2'b00));
  assign yoff    = yc - YEAR_BASE;

  // Month days
  assign month_ok  = (month >= 7'd1) && (month <= 7'd12);
  assign month_idx = month[3:0] - 4'd1;
  assign mdays     = month_ok
                     ? cum_days(month_idx) + 9'((leap && month > 7'd2) ? 1 : 0)
                     : 9'd0;

  // Calculation steps
  always_ff @(posedge clk) begin
    if (cmd.year_en) begin
      yc   <= yc_c;
      q100 <= qprod[RECIP_SHIFT+6:RECIP_SHIFT];
      ok   <= (phase == PH_DONE) && !malformed && (day != 7'd0);
    end
    if (cmd.days_en) begin
      leap  <= leap_c;
      ydays <= DAYS_W'(yoff) * DAYS_PER_YEAR + DAYS_W'(yc >> 2) - DAYS_W'(q100)
               + DAYS_W'(q100 >> 2) - DAYS_W'(leap_c) - LEAPS_BASE;
    end
    if (cmd.month_en) begin
      days <= ydays + DAYS_W'(mdays) + DAYS_W'(day) - DAYS_W'(1);
    end
    if (cmd.mul_en) begin
      // full-width product: day count times seconds per day
      dsecs <= EPOCH_W'(days) * EPOCH_W'(SECS_PER_DAY);
      tod   <= TOD_W'(hour) * TOD_W'(3600) + TOD_W'(minute) * TOD_W'(60) + TOD_W'(second);
    end
    if (cmd.sum_en) begin
      epoch_sum <= dsecs + EPOCH_W'(tod);
    end
  end

  // Result registers, held while the result waits
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      well_formed   <= ok;
      eligible      <= ok && (CUTOFF_W'(epoch_sum) < cutoff);
      epoch_seconds <= ok ? epoch_sum : '0;
    end
  end

endmodule

### src/timestamped_name_expiry_check_core.sv
// Top level of the timestamped name expiry check.
// Depends on tnec_pkg, tnec_ctrl and tnec_dp.
//
// Usage:
// - Input channel (in_valid / in_stall, name_char, last_char) carries one name
//   byte per transfer; last_char marks the final byte. The scanner looks for
//   "-YYYYMMDD-HHMMSS." and ignores bytes after the dot.
// - Earlier bytes are taken while idle. The final byte starts a six-step
//   calculation (year clamp and divide by 100, whole-year days, month and day,
//   multiply to seconds, sum, cutoff compare), one step a cycle.
// - The result (eligible, well_formed, epoch_seconds) is presented on the
//   output channel (out_valid / out_stall) after the cutoff compare step and
//   transfers when out_stall is low.
// - in_stall is high from the last byte until the result transfers; a stalled
//   receiver holds the block with the result unchanged.
// - cutoff_we / cutoff_wdata write the cutoff (seconds since 1970) while idle.
// - Synchronous reset (rst) clears the cutoff to zero, returns the scanner to
//   searching for the first dash and drops any pending result.
module timestamped_name_expiry_check_core import tnec_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cutoff_we,
  input  logic [CUTOFF_W-1:0] cutoff_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          name_char,
  input  logic                last_char,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                eligible,
  output logic                well_formed,
  output logic [EPOCH_W-1:0]  epoch_seconds
);

  cmd_t cmd;

  // Controller
  tnec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_char (last_char),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath
  tnec_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .name_char     (name_char),
    .cutoff_we     (cutoff_we),
    .cutoff_wdata  (cutoff_wdata),
    .eligible      (eligible),
    .well_formed   (well_formed),
    .epoch_seconds (epoch_seconds)
  );

endmodule

### sim/expiry_checker.sv
// Scoreboard for the timestamped name expiry check: follows the name bytes on
// the input channel, predicts each verdict and compares it with the output channel.
// Depends on tnec_pkg for widths, name characters and the scanner phase enum.
module expiry_checker import tnec_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cutoff_we,
  input  logic [CUTOFF_W-1:0] cutoff_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          name_char,
  input  logic                last_char,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                eligible,
  input  logic                well_formed,
  input  logic [EPOCH_W-1:0]  epoch_seconds,
  output int                  errors,
  output int                  outstanding,
  output int                  results_checked,
  output int                  good_names,
  output int                  eligible_names
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               eligible;
    logic               well_formed;
    logic [EPOCH_W-1:0] epoch;
  } name_verdict_t;

  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  name_verdict_t       expected_verdicts [$];
  logic [CUTOFF_W-1:0] cutoff_now;

  // scanner copy
  phase_t      scan_phase;
  logic [3:0]  field_len;
  logic        bad_name;
  int unsigned yr, mo, dy, hh, mi, ss;

  function automatic longint unsigned leaps_up_to(input int unsigned y);
    return longint'(y / 4) - longint'(y / 100) + longint'(y / 400);
  endfunction

  // Gregorian seconds since 1970; out-of-range years fold to 1970
  function automatic logic [EPOCH_W-1:0] seconds_since_1970(
    input int unsigned y_in, m, d, h, mn, s
  );
    int unsigned     y;
    bit              leap;
    longint unsigned days;
    longint unsigned total;
    y = (y_in >= 9999 || y_in < 1970) ? 1970 : y_in;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    days = 365 * longint'(y - 1970) + leaps_up_to(y - 1) - leaps_up_to(1969);
    if (m >= 1 && m <= 12) begin
      for (int i = 0; i + 1 < m; i++) begin
        days += MONTH_LEN[i];
        if (i == 1 && leap) days += 1;
      end
    end
    days += longint'(d - 1);
    total = days * 86400 + longint'(h) * 3600 + longint'(mn) * 60 + longint'(s);
    return total[EPOCH_W-1:0];
  endfunction

  task automatic clear_scan();
    scan_phase = PH_SEEK;
    field_len  = '0;
    bad_name   = 1'b0;
    yr = 0; mo = 0; dy = 0; hh = 0; mi = 0; ss = 0;
  endtask

  // One name byte through the scanner; the final byte queues a verdict
  task automatic scan_name_byte(input logic [7:0] ch, input logic is_last);
    logic          is_digit;
    int unsigned   dig;
    int unsigned   pos;
    logic          ok;
    name_verdict_t v;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dig = is_digit ? int'(ch - CH_ZERO) : 0;
    case (scan_phase)
      PH_SEEK: begin
        if (ch == CH_DASH) begin
          scan_phase = PH_DATE;
          field_len  = '0;
        end
      end
      PH_DATE: begin
        if (ch == CH_DASH) begin
          if (field_len != DATE_LEN) bad_name = 1'b1;
          scan_phase = PH_TIME;
          field_len  = '0;
        end else begin
          pos = field_len;
          if (field_len < COUNT_MAX) field_len++;
          if (!is_digit || pos >= 8) bad_name = 1'b1;
          else if (pos < 4) yr = yr * 10 + dig;
          else if (pos < 6) mo = mo * 10 + dig;
          else dy = dy * 10 + dig;
        end
      end
      PH_TIME: begin
        if (ch == CH_DOT) begin
          if (field_len != TIME_LEN) bad_name = 1'b1;
          scan_phase = PH_DONE;
        end else begin
          pos = field_len;
          if (field_len < COUNT_MAX) field_len++;
          if (!is_digit || pos >= 6) bad_name = 1'b1;
          else if (pos < 2) hh = hh * 10 + dig;
          else if (pos < 4) mi = mi * 10 + dig;
          else ss = ss * 10 + dig;
        end
      end
      default: ;  // bytes after the dot are ignored
    endcase

    if (is_last) begin
      ok = (scan_phase == PH_DONE) && !bad_name && (dy != 0);
      v.well_formed = ok;
      v.epoch       = ok ? seconds_since_1970(yr, mo, dy, hh, mi, ss) : '0;
      v.eligible    = ok && (v.epoch < cutoff_now);
      if (ok) good_names++;
      if (v.eligible) eligible_names++;
      expected_verdicts.push_back(v);
      clear_scan();
    end
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
    results_checked = 0;
    good_names = 0;
    eligible_names = 0;
    cutoff_now = '0;
    clear_scan();
  end

  always @(posedge clk) begin
    name_verdict_t want;
    if (rst) begin
      cutoff_now = '0;
      clear_scan();
      expected_verdicts.delete();
    end else begin
      if (cutoff_we) cutoff_now = cutoff_wdata;

      // result transfer: compare against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: eligible %0b well_formed %0b epoch %0d",
                   $time, eligible, well_formed, epoch_seconds);
        end else begin
          want = expected_verdicts.pop_front();
          results_checked++;
          if (eligible !== want.eligible) begin
            errors++;
            $display("%0t: eligible expected %0b, got %0b", $time, want.eligible, eligible);
          end
          if (well_formed !== want.well_formed) begin
            errors++;
            $display("%0t: well_formed expected %0b, got %0b",
                     $time, want.well_formed, well_formed);
          end
          if (epoch_seconds !== want.epoch) begin
            errors++;
            $display("%0t: epoch_seconds expected %0d, got %0d",
                     $time, want.epoch, epoch_seconds);
          end
        end
      end

      // name byte transfer
      if (in_valid && !in_stall) scan_name_byte(name_char, last_char);
    end
    outstanding = expected_verdicts.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for timestamped_name_expiry_check_core: clock, reset, name
// stimulus, cutoff writes, receiver stalls and the final verdict.
// Depends on tnec_pkg, the core and the expiry_checker scoreboard.
module tb_top import tnec_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] name_bytes_t [$];

  localparam int LONG_HOLD = 300;
  localparam logic [CUTOFF_W-1:0] Y2K_SECONDS = 40'd946684800;

  logic                clk;
  logic                rst;
  logic                cutoff_we;
  logic [CUTOFF_W-1:0] cutoff_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          name_char;
  logic                last_char;
  logic                out_valid;
  logic                out_stall;
  logic                eligible;
  logic                well_formed;
  logic [EPOCH_W-1:0]  epoch_seconds;

  int errors, outstanding, results_checked, good_names, eligible_names;

  int send_pct  = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int bytes_sent = 0;
  int names_sent = 0;
  int cutoffs_used = 0;

  timestamped_name_expiry_check_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cutoff_we     (cutoff_we),
    .cutoff_wdata  (cutoff_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .name_char     (name_char),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .eligible      (eligible),
    .well_formed   (well_formed),
    .epoch_seconds (epoch_seconds)
  );

  expiry_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cutoff_we       (cutoff_we),
    .cutoff_wdata    (cutoff_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .name_char       (name_char),
    .last_char       (last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .eligible        (eligible),
    .well_formed     (well_formed),
    .epoch_seconds   (epoch_seconds),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .good_names      (good_names),
    .eligible_names  (eligible_names)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_requested != holds_served) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_served++;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic name_bytes_t text_bytes(input string s);
    name_bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // n decimal digits of v, most significant first
  function automatic void put_digits(ref name_bytes_t q, input int unsigned v, input int n);
    int unsigned div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      q.push_back(8'(CH_ZERO + (v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom); while (b >= CH_ZERO && b <= CH_NINE);
    return b;
  endfunction

  // Mostly well-formed names with random content, some broken ones, some noise
  function automatic name_bytes_t random_name();
    name_bytes_t q, date_d, time_d;
    int          kind, flaw, n, idx, pick;
    int unsigned yr;
    logic [7:0]  b;
    kind = $urandom_range(99);
    flaw = (kind >= 70) ? $urandom_range(5) : -1;

    // noise
    if (kind >= 90) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        case ($urandom_range(3))
          0:       q.push_back(CH_DASH);
          1:       q.push_back(8'(CH_ZERO + $urandom_range(9)));
          default: q.push_back(8'($urandom));
        endcase
      end
      return q;
    end

    // date and time digits
    pick = $urandom_range(9);
    if (pick < 6) yr = $urandom_range(1970, 2150);
    else if (pick < 8) yr = $urandom_range(9999);
    else begin
      case ($urandom_range(7))
        0: yr = 1969;
        1: yr = 1970;
        2: yr = 9998;
        3: yr = 9999;
        4: yr = 0;
        5: yr = 2000;
        6: yr = 2100;
        default: yr = 2400;
      endcase
    end
    put_digits(date_d, yr, 4);
    put_digits(date_d, ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(99), 2);
    put_digits(date_d, ($urandom_range(99) < 85) ? $urandom_range(1, 31) : $urandom_range(99), 2);
    put_digits(time_d, ($urandom_range(99) < 90) ? $urandom_range(23) : $urandom_range(99), 2);
    put_digits(time_d, ($urandom_range(99) < 90) ? $urandom_range(59) : $urandom_range(99), 2);
    put_digits(time_d, ($urandom_range(99) < 90) ? $urandom_range(59) : $urandom_range(99), 2);

    // broken fields
    case (flaw)
      0, 1: begin
        if ($urandom_range(1)) begin
          if (flaw == 0) date_d.delete($urandom_range(date_d.size() - 1));
          else time_d.delete($urandom_range(time_d.size() - 1));
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            if (flaw == 0) date_d.push_back(8'(CH_ZERO + $urandom_range(9)));
            else time_d.push_back(8'(CH_ZERO + $urandom_range(9)));
          end
        end
      end
      2: begin
        if ($urandom_range(1)) date_d[$urandom_range(7)] = non_digit();
        else time_d[$urandom_range(5)] = non_digit();
      end
      3: time_d[$urandom_range(5)] = CH_DASH;
      default: ;
    endcase

    // assemble prefix, fields and suffix
    n = $urandom_range(4);
    repeat (n) begin
      do b = 8'($urandom); while (b == CH_DASH);
      q.push_back(b);
    end
    q.push_back(CH_DASH);
    foreach (date_d[i]) q.push_back(date_d[i]);
    q.push_back(CH_DASH);
    foreach (time_d[i]) q.push_back(time_d[i]);
    if (flaw != 5) begin
      q.push_back(CH_DOT);
      n = $urandom_range(4);
      repeat (n) q.push_back(8'($urandom));
    end
    // cut short
    if (flaw == 4) begin
      idx = $urandom_range(1, q.size() - 1);
      q = q[0:idx-1];
    end
    return q;
  endfunction

  // One byte transfer; valid stays up into the next byte unless the sender idles
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_pct) begin
      in_valid  = 1'b0;
      name_char = 8'($urandom);
      last_char = 1'($urandom);
      @(negedge clk);
    end
    in_valid  = 1'b1;
    name_char = b;
    last_char = is_last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_name(input name_bytes_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    names_sent++;
  endtask

  // Cutoff write once the block has drained
  task automatic write_cutoff(input logic [CUTOFF_W-1:0] v);
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (12) @(negedge clk);
    cutoff_we    = 1'b1;
    cutoff_wdata = v;
    @(negedge clk);
    cutoff_we    = 1'b0;
    cutoff_wdata = 40'($urandom);
    cutoffs_used++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_pct = 65; stall_pct = 0;  end
      2:       begin send_pct = 0;  stall_pct = 65; end
      3:       begin send_pct = 17; stall_pct = 17; end
      default: begin send_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  function automatic logic [CUTOFF_W-1:0] typical_cutoff();
    longint unsigned v;
    v = (longint'($urandom_range(5)) << 32) | longint'($urandom);
    return v[CUTOFF_W-1:0];
  endfunction

  string corner_names [] = '{
    "-19700101-000000.",
    "a.b-19991231-235959.log",
    "-20000101-000000.",
    "-99991231-235959.",
    "-99981231-235959.",
    "-00000101-000000.",
    "-19691231-120000.",
    "-20240100-120000.",
    "-20241301-000000.",
    "-20240015-000000.",
    "-20241231-235959.",
    "-21000301-000000.",
    "-20000301-000000.",
    "-2024011-120000.",
    "-202401151234567890-1.",
    "-20240115-1200000.",
    "-20240115-12-000.",
    "-2024a115-120000.",
    "-20240115-120000",
    "noname",
    "-",
    "-20240199-999999.",
    "-20240115-120000.-x-5"
  };

  initial begin
    name_bytes_t     q;
    int              mark;
    logic [CUTOFF_W-1:0] cut;

    rst          = 1'b1;
    cutoff_we    = 1'b0;
    cutoff_wdata = '0;
    in_valid     = 1'b0;
    name_char    = '0;
    last_char    = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed corners, cutoff at the start of 2000
    write_cutoff(Y2K_SECONDS);
    foreach (corner_names[i]) send_name(text_bytes(corner_names[i]));
    // extreme byte values around a leap day stamp
    q = text_bytes("-20240229-000000.");
    q.push_front(8'h00);
    q.push_front(8'hFF);
    q.push_back(8'h00);
    q.push_back(8'hFF);
    send_name(q);

    // Random names under several cutoffs and idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       cut = '1;
        1:       cut = '0;
        2:       cut = {8'($urandom), 32'($urandom)};
        default: cut = typical_cutoff();
      endcase
      write_cutoff(cut);
      set_idling(p % 4);
      mark = bytes_sent;
      while (bytes_sent - mark < 60) send_name(random_name());
    end

    // Long receiver hold-off while names keep coming
    write_cutoff(typical_cutoff());
    set_idling(0);
    holds_requested++;
    repeat (10) send_name(random_name());

    // Drain
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d name bytes in %0d names under %0d cutoff settings, %0d results checked.",
             bytes_sent, names_sent, cutoffs_used, results_checked);
    $display("Of the predicted verdicts %0d were well formed and %0d below the cutoff.",
             good_names, eligible_names);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
